// ===== rtl/crlf_line_framer_idle_gap_defines.svh =====
// ----------------------------------------------------------------------------
// CRLF line framer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CRLF_LINE_FRAMER_IDLE_GAP_DEFINES_SVH
`define CRLF_LINE_FRAMER_IDLE_GAP_DEFINES_SVH

// same-cycle implication
`define CLFIG_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define CLFIG_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/clfig_pkg.sv =====
// ----------------------------------------------------------------------------
// CRLF line framer package
// Constants, state type and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package clfig_pkg;

    localparam int LINE_SIZE_DEF = 64;
    localparam logic [31:0] GAP_RESET = 32'd50000;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FETCH,
        S_SEND
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic fetch;
        logic send;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
        logic last_char;
    } dp_status_t;

endpackage

// ===== rtl/clfig_if.sv =====
// ----------------------------------------------------------------------------
// CRLF line framer channels
// Valid/ready channels for received bytes, line results and configuration.
// ----------------------------------------------------------------------------
interface clfig_rx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] arrival_us;
    logic        batch_end;

    modport source (output valid, rx_byte, arrival_us, batch_end, input ready);
    modport sink (input valid, rx_byte, arrival_us, batch_end, output ready);
endinterface

interface clfig_line_if;
    logic        valid;
    logic        ready;
    logic [7:0]  line_char;
    logic        line_last;
    logic        line_empty;
    logic        end_cause;
    logic [31:0] stamp_us;

    modport source (output valid, line_char, line_last, line_empty, end_cause, stamp_us,
                    input ready);
    modport sink (input valid, line_char, line_last, line_empty, end_cause, stamp_us,
                  output ready);
endinterface

interface clfig_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] gap_limit_us;

    modport source (output valid, gap_limit_us, input ready);
    modport sink (input valid, gap_limit_us, output ready);
endinterface

// ===== rtl/crlf_line_framer_idle_gap.sv =====
// ----------------------------------------------------------------------------
// CRLF line framer with idle-gap discard
// Frames received bytes into CR LF terminated lines, one character per beat.
// ----------------------------------------------------------------------------
// Each received byte is accepted, then gap checked, stored and CR LF
// checked; intake is held off while a completed line is read out of the
// line store, each character by a store read and then an output register
// load, plus any stall from the result side; an empty line is still sent as
// one beat flagged last and empty. A partial line is dropped on the
// first byte of a batch arriving more than gap_limit_us after the previous
// batch end; a store that fills to LINE_SIZE-1 bytes is flushed at batch end
// with end_cause set. The result register lets the next byte be accepted
// while the final beat of a line still waits. The gap limit may be written
// at any time the block is idle; no clearing pass follows reset.
module crlf_line_framer_idle_gap #(
    parameter int LINE_SIZE = clfig_pkg::LINE_SIZE_DEF
) (
    input logic            clk,
    input logic            rst_n,
    clfig_rx_if.sink       rx,
    clfig_line_if.source   lines,
    clfig_cfg_if.sink      cfg
);

    clfig_pkg::ctrl_cmd_t  cmd;
    clfig_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    clfig_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    clfig_dp #(
        .LINE_SIZE (LINE_SIZE)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .rx_byte          (rx.rx_byte),
        .arrival_us       (rx.arrival_us),
        .batch_end        (rx.batch_end),
        .cfg_valid        (cfg.valid),
        .cfg_gap_limit_us (cfg.gap_limit_us),
        .out_valid        (lines.valid),
        .out_ready        (lines.ready),
        .line_char        (lines.line_char),
        .line_last        (lines.line_last),
        .line_empty       (lines.line_empty),
        .end_cause        (lines.end_cause),
        .stamp_us         (lines.stamp_us)
    );

endmodule

// ===== rtl/clfig_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module clfig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/clfig_ctrl.sv =====
// ----------------------------------------------------------------------------
// CRLF line framer controller
// Sequences intake, evaluation and character-by-character line readout.
// ----------------------------------------------------------------------------
module clfig_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  clfig_pkg::dp_status_t status,
    output clfig_pkg::ctrl_cmd_t  cmd
);

    clfig_pkg::state_t state_reg;
    clfig_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clfig_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clfig_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = clfig_pkg::S_EVAL;
                end
            end
            clfig_pkg::S_EVAL:
            begin
                state_next = status.emit ? clfig_pkg::S_FETCH : clfig_pkg::S_IDLE;
            end
            clfig_pkg::S_FETCH:
            begin
                state_next = clfig_pkg::S_SEND;
            end
            clfig_pkg::S_SEND:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_char ? clfig_pkg::S_IDLE : clfig_pkg::S_FETCH;
                end
            end
            default:
            begin
                state_next = clfig_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            clfig_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            clfig_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            clfig_pkg::S_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            clfig_pkg::S_SEND:
            begin
                cmd.send = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/clfig_dp.sv =====
// ----------------------------------------------------------------------------
// CRLF line framer datapath
// Line store, fill tracking, gap check, CR LF detection and output register.
// ----------------------------------------------------------------------------
`include "crlf_line_framer_idle_gap_defines.svh"

module clfig_dp #(
    parameter int LINE_SIZE = clfig_pkg::LINE_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  clfig_pkg::ctrl_cmd_t  cmd,
    output clfig_pkg::dp_status_t status,
    input  logic [7:0]            rx_byte,
    input  logic [31:0]           arrival_us,
    input  logic                  batch_end,
    input  logic                  cfg_valid,
    input  logic [31:0]           cfg_gap_limit_us,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            line_char,
    output logic                  line_last,
    output logic                  line_empty,
    output logic                  end_cause,
    output logic [31:0]           stamp_us
);

    localparam int CNT_W = $clog2(LINE_SIZE);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(LINE_SIZE - 1);
    localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    // control state
    logic [CNT_W-1:0] fill_reg;
    logic             mid_reg;
    logic [31:0]      last_us_reg;
    logic [31:0]      gap_limit_reg;
    logic             out_valid_reg;
    logic [CNT_W-1:0] idx_reg;

    // payload
    logic [7:0]       byte_reg;
    logic [31:0]      now_reg;
    logic             end_reg;
    logic [7:0]       last1_reg;
    logic [7:0]       last2_reg;
    logic [CNT_W-1:0] len_reg;
    logic             cause_reg;
    logic [7:0]       char_reg;
    logic             olast_reg;
    logic             oempty_reg;
    logic             ocause_reg;
    logic [31:0]      ostamp_reg;

    logic [31:0]      gap;
    logic             discard;
    logic [CNT_W-1:0] fill_eff;
    logic             store_ok;
    logic [CNT_W-1:0] fill_st;
    logic [7:0]       l1;
    logic [7:0]       l2;
    logic             crlf;
    logic             ovf;
    logic [CNT_W-1:0] len_next;
    logic [7:0]       rd_data;
    logic             char_last;

    always_comb
    begin
        gap      = now_reg - last_us_reg;
        discard  = !mid_reg && (fill_reg != '0) && (gap > gap_limit_reg);
        fill_eff = discard ? '0 : fill_reg;
        store_ok = fill_eff < FULL;
        fill_st  = store_ok ? fill_eff + ONE : fill_eff;
        l1       = store_ok ? byte_reg : last1_reg;
        l2       = store_ok ? last1_reg : last2_reg;
        crlf     = (fill_st >= TWO) && (l2 == clfig_pkg::CH_CR) && (l1 == clfig_pkg::CH_LF);
        ovf      = end_reg && !crlf && (fill_st >= FULL);
        len_next = crlf ? fill_st - TWO : fill_st;
        char_last = (len_reg == '0) || (idx_reg == len_reg - ONE);
    end

    assign status.emit      = crlf || ovf;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_char = char_last;

    clfig_ram #(
        .WIDTH (8),
        .DEPTH (LINE_SIZE)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.eval && store_ok),
        .wr_addr (fill_eff),
        .wr_data (byte_reg),
        .rd_en   (cmd.fetch),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            mid_reg       <= 1'b0;
            last_us_reg   <= '0;
            gap_limit_reg <= clfig_pkg::GAP_RESET;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gap_limit_reg <= cfg_gap_limit_us;
            end
            if (cmd.eval)
            begin
                fill_reg <= (crlf || ovf) ? '0 : fill_st;
                mid_reg  <= !end_reg;
                idx_reg  <= '0;
                if (end_reg)
                begin
                    last_us_reg <= now_reg;
                end
            end
            if (cmd.send)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + ONE;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= rx_byte;
            now_reg  <= arrival_us;
            end_reg  <= batch_end;
        end
        if (cmd.eval)
        begin
            last1_reg <= l1;
            last2_reg <= l2;
            len_reg   <= len_next;
            cause_reg <= ovf;
        end
        if (cmd.send)
        begin
            // an empty line reads nothing useful from the store; force zero
            char_reg   <= (len_reg == '0) ? 8'h00 : rd_data;
            olast_reg  <= char_last;
            oempty_reg <= (len_reg == '0);
            ocause_reg <= cause_reg;
            ostamp_reg <= now_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_char  = char_reg;
    assign line_last  = olast_reg;
    assign line_empty = oempty_reg;
    assign end_cause  = ocause_reg;
    assign stamp_us   = ostamp_reg;

    `CLFIG_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FULL, "fill count past line size")
    `CLFIG_ASSERT_NOW(a_send_free, cmd.send, !out_valid_reg || out_ready,
                      "output beat overwritten before taken")
    `CLFIG_ASSERT_NEXT(a_emit_clears, cmd.eval && (crlf || ovf), fill_reg == '0,
                       "store not cleared after line end")
    `CLFIG_ASSERT_NEXT(a_last_empty, cmd.send && (len_reg == '0), olast_reg && oempty_reg,
                       "empty line marker not flagged last")

endmodule
